>>> src/rcp_pkg.sv
`timescale 1ns / 1ps

package rcp_pkg;

    localparam int PIX_W       = 8;
    localparam int SUM_W       = 20;
    localparam int IDX_W       = 12;
    localparam int DIM_W       = 13;
    localparam int CFG_INDEX_W = 2;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic KIND_ROW = 1'b0;
    localparam logic KIND_COL = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // result queue: two words may enter per pixel
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = RES_PTR_W + 1;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] index;
        logic [SUM_W-1:0] total;
        logic             frame_done;
    } t_result;

    typedef struct packed {
        logic    wr0;
        logic    wr1;
        t_result word0;
        t_result word1;
    } t_push;

endpackage

>>> src/row_column_projection_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// pixel     in         i_valid / o_ready          i_pixel
// result    out        o_valid / i_ready          o_kind o_index o_total o_frame_done
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// One pixel per cycle. A pixel is accepted, its column entry is read from the
// column sum memory; as the pixel leaves stage 1 the sum is written back and its
// words enter a four-word result queue. The result port drains at most one word
// per cycle, so a pixel that ends the last row's last column gives two words of
// output. Reset is synchronous: positions, row sum and queue are cleared, the
// dimensions return to 640 by 480, the column memory is not touched. A stalled
// result port holds the pipeline once the queue cannot take two more words.

module row_column_projection_unit #(
    parameter int MAX_WIDTH  = rcp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rcp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [rcp_pkg::PIX_W-1:0]        i_pixel,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_kind,
    output logic [rcp_pkg::IDX_W-1:0]        o_index,
    output logic [rcp_pkg::SUM_W-1:0]        o_total,
    output logic                             o_frame_done,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rcp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rcp_pkg::DIM_W-1:0]        i_cfg_data
);
    import rcp_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // zero counts as one, anything above the maximum as the maximum
    function automatic int f_clamp_last(input logic [DIM_W-1:0] v, input int maxv);
        int t;
        t = int'(v);
        if (t == 0) t = 1;
        if (t > maxv) t = maxv;
        return t - 1;
    endfunction

    logic [CW-1:0]    r_w_last;
    logic [RW-1:0]    r_h_last;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [SUM_W-1:0] r_row_total;

    logic [SUM_W-1:0] r_col_mem [MAX_WIDTH];
    logic [SUM_W-1:0] r_rd;
    logic             r_fwd;
    logic [SUM_W-1:0] r_fwd_val;

    logic             r_s1_v;
    logic [CW-1:0]    r_s1_col;
    logic [RW-1:0]    r_s1_row;
    logic [PIX_W-1:0] r_s1_px;
    logic             r_s1_row0;
    logic             r_s1_last_col;
    logic             r_s1_last_row;
    logic [SUM_W-1:0] r_s1_row_total;

    logic             w_accept;
    logic             w_s1_fire;
    logic             w_last_col;
    logic             w_last_row;
    logic [SUM_W:0]   w_row_raw;
    logic [SUM_W-1:0] w_row_sum;
    logic [SUM_W-1:0] w_base;
    logic [SUM_W:0]   w_csum_raw;
    logic [SUM_W-1:0] w_csum;
    t_result          w_col_word;
    t_result          w_row_word;
    t_push            w_push;
    t_result          w_out;
    logic [RES_CNT_W-1:0] w_fifo_cnt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(f_clamp_last(RESET_WIDTH, MAX_WIDTH));
            r_h_last <= RW'(f_clamp_last(RESET_HEIGHT, MAX_HEIGHT));
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_w_last <= CW'(f_clamp_last(i_cfg_data, MAX_WIDTH));
                REG_FRAME_HEIGHT: r_h_last <= RW'(f_clamp_last(i_cfg_data, MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    // room for two words, counted before this cycle's pop
    assign w_s1_fire = r_s1_v && (w_fifo_cnt <= RES_CNT_W'(RES_DEPTH - 2));
    assign o_ready   = !r_s1_v || w_s1_fire;
    assign w_accept  = i_valid && o_ready;

    assign w_last_col = (r_col >= r_w_last);
    assign w_last_row = (r_row >= r_h_last);
    assign w_row_raw  = {1'b0, r_row_total} + (SUM_W+1)'(i_pixel);
    assign w_row_sum  = w_row_raw[SUM_W] ? SUM_MAX : w_row_raw[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_row_total <= '0;
            r_s1_v      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_v <= 1'b1;
                if (w_last_col) begin
                    r_col       <= '0;
                    r_row_total <= '0;
                    r_row       <= w_last_row ? '0 : RW'(r_row + 1'b1);
                end else begin
                    r_col       <= CW'(r_col + 1'b1);
                    r_row_total <= w_row_sum;
                end
            end else if (w_s1_fire) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_col       <= r_col;
            r_s1_row       <= r_row;
            r_s1_px        <= i_pixel;
            r_s1_row0      <= (r_row == '0);
            r_s1_last_col  <= w_last_col;
            r_s1_last_row  <= w_last_row;
            r_s1_row_total <= w_row_sum;
        end
    end

    // column memory: read on accept, write back when the pixel leaves stage 1
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd      <= r_col_mem[r_col];
            r_fwd     <= w_s1_fire && (r_s1_col == r_col);
            r_fwd_val <= w_csum;
        end
        if (w_s1_fire) begin
            r_col_mem[r_s1_col] <= w_csum;
        end
    end

    assign w_base     = r_s1_row0 ? '0 : (r_fwd ? r_fwd_val : r_rd);
    assign w_csum_raw = {1'b0, w_base} + (SUM_W+1)'(r_s1_px);
    assign w_csum     = w_csum_raw[SUM_W] ? SUM_MAX : w_csum_raw[SUM_W-1:0];

    always_comb begin
        w_col_word.kind       = KIND_COL;
        w_col_word.index      = IDX_W'(r_s1_col);
        w_col_word.total      = w_csum;
        w_col_word.frame_done = 1'b0;
        w_row_word.kind       = KIND_ROW;
        w_row_word.index      = IDX_W'(r_s1_row);
        w_row_word.total      = r_s1_row_total;
        w_row_word.frame_done = r_s1_last_row;

        // column word goes first on the last row
        w_push.wr0   = w_s1_fire && (r_s1_last_row || r_s1_last_col);
        w_push.wr1   = w_s1_fire && r_s1_last_row && r_s1_last_col;
        w_push.word0 = r_s1_last_row ? w_col_word : w_row_word;
        w_push.word1 = w_row_word;
    end

    rcp_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_count (w_fifo_cnt),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (w_out)
    );

    assign o_kind       = w_out.kind;
    assign o_index      = w_out.index;
    assign o_total      = w_out.total;
    assign o_frame_done = w_out.frame_done;

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_cnt <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last_col) |=> (r_col == '0))
        else $error("column position did not wrap at row end");

    a_done_is_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> (o_kind == KIND_ROW))
        else $error("frame end flagged on a column word");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !w_s1_fire) |=> (r_s1_v && $stable(r_s1_col) && $stable(r_s1_px)))
        else $error("stalled pixel lost its column or value");

endmodule

>>> src/rcp_result_fifo.sv
`timescale 1ns / 1ps

module rcp_result_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rcp_pkg::t_push             i_push,
    output logic [rcp_pkg::RES_CNT_W-1:0] o_count,
    output logic                       o_valid,
    input  logic                       i_ready,
    output rcp_pkg::t_result           o_word
);
    import rcp_pkg::*;

    t_result              r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wp;
    logic [RES_PTR_W-1:0] r_rp;
    logic [RES_CNT_W-1:0] r_cnt;
    logic [RES_PTR_W-1:0] n_wp;
    logic [RES_CNT_W-1:0] n_cnt;
    logic                 w_pop;
    logic [1:0]           w_nps;

    assign w_pop   = (r_cnt != '0) && i_ready;
    // word1 only ever comes along with word0
    assign w_nps   = {1'b0, i_push.wr0} + {1'b0, i_push.wr1};
    assign n_wp    = r_wp + RES_PTR_W'(w_nps);
    assign n_cnt   = r_cnt + RES_CNT_W'(w_nps) - RES_CNT_W'(w_pop);
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push.wr0) begin
            r_mem[r_wp] <= i_push.word0;
        end
        if (i_push.wr1) begin
            r_mem[r_wp + RES_PTR_W'(1)] <= i_push.word1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_cnt <= n_cnt;
            if (w_pop) begin
                r_rp <= r_rp + RES_PTR_W'(1);
            end
        end
    end

endmodule

>>> test/row_column_projection_unit_tb.sv
`timescale 1ns / 1ps

module row_column_projection_unit_tb;

    import rcp_pkg::*;

    localparam int MAX_W          = DEF_MAX_WIDTH;
    localparam int MAX_H          = DEF_MAX_HEIGHT;
    localparam int SLOT_W         = $clog2(MAX_W);
    localparam int SETTLE_CYCLES  = 10;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_PIXELS  = 2000;

    // indexes past the two registers; writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {DRAIN_FREE, DRAIN_HALF, DRAIN_SLOW} t_drain_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [PIX_W-1:0]       i_pixel = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic                   o_kind;
    logic [IDX_W-1:0]       o_index;
    logic [SUM_W-1:0]       o_total;
    logic                   o_frame_done;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]       i_cfg_data = '0;

    // projection state mirrored on the testbench side
    logic [SUM_W-1:0] col_acc [MAX_W];
    logic [SUM_W-1:0] row_acc = '0;
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;
    logic [DIM_W-1:0] cfg_width = RESET_WIDTH;
    logic [DIM_W-1:0] cfg_height = RESET_HEIGHT;

    t_result     pending_sums [$];
    int          mismatches = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;
    t_drain_mode drain_mode = DRAIN_FREE;
    int unsigned drain_left = 0;

    row_column_projection_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_index      (o_index),
        .o_total      (o_total),
        .o_frame_done (o_frame_done),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned bounded_dim(input logic [DIM_W-1:0] v,
                                                input int unsigned maxv);
        if (v == '0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    function automatic logic [SUM_W-1:0] clip_add(input logic [SUM_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // column word first on the last row, then the row word at the row's end
    task automatic accumulate_pixel(input logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        logic [SLOT_W-1:0] slot;
        logic [SUM_W-1:0] csum;
        bit               last_col;
        bit               last_row;
        t_result          sum_word;
        w = bounded_dim(cfg_width, MAX_W);
        h = bounded_dim(cfg_height, MAX_H);
        slot = SLOT_W'((col_pos < MAX_W) ? col_pos : MAX_W - 1);
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        csum = (row_pos == 0) ? SUM_W'(px) : clip_add(col_acc[slot], px);
        col_acc[slot] = csum;
        row_acc = clip_add(row_acc, px);
        if (last_row) begin
            sum_word = '{KIND_COL, IDX_W'(col_pos), csum, 1'b0};
            pending_sums.insert(pending_sums.size(), sum_word);
        end
        if (last_col) begin
            sum_word = '{KIND_ROW, IDX_W'(row_pos), row_acc, last_row};
            pending_sums.insert(pending_sums.size(), sum_word);
            row_acc = '0;
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH: begin
                        cfg_width = i_cfg_data;
                    end
                    REG_FRAME_HEIGHT: begin
                        cfg_height = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_valid && o_ready)
                accumulate_pixel(i_pixel);
            if (o_valid && i_ready) begin
                got = '{o_kind, o_index, o_total, o_frame_done};
                if (pending_sums.size() == 0) begin
                    $error("unexpected word: kind %0d index %0d total %0d done %0d",
                           got.kind, got.index, got.total, got.frame_done);
                    mismatches++;
                end else begin
                    want = pending_sums.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        mismatches++;
                    end
                    if (got.index !== want.index) begin
                        $error("index: expected %0d, got %0d", want.index, got.index);
                        mismatches++;
                    end
                    if (got.total !== want.total) begin
                        $error("total: expected %0d, got %0d", want.total, got.total);
                        mismatches++;
                    end
                    if (got.frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0d, got %0d",
                               want.frame_done, got.frame_done);
                        mismatches++;
                    end
                end
            end
        end
    end

    // result side backpressure, switching between free, choppy and slow drain
    always @(negedge i_clk) begin
        if (drain_left == 0) begin
            drain_mode = t_drain_mode'($urandom_range(0, 2));
            drain_left = $urandom_range(20, 200);
        end
        drain_left--;
        case (drain_mode)
            DRAIN_FREE: begin
                i_ready <= 1'b1;
            end
            DRAIN_HALF: begin
                i_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_ready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // entered and left at a falling edge; valid stays up inside a burst
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_pixel <= px;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [DIM_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait for every expected word, then let the pipeline empty
    task automatic settle_block();
        i_valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending_sums.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic test_defaults_and_spare_regs();
        // 640x480 after reset: a few pixels make no word
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h5A);
        settle_block();
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, '0);
        // shrink under the running row; height 0 acts as 1
        write_reg(REG_FRAME_WIDTH, 13'd4);
        write_reg(REG_FRAME_HEIGHT, '0);
        send_pixel(8'hA5);
        settle_block();
    endtask

    task automatic test_extreme_pixels();
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        repeat (3) send_pixel('1);
        repeat (3) send_pixel('0);
        settle_block();
        // 1x1: every pixel is a whole frame, two words each
        write_reg(REG_FRAME_WIDTH, 13'd1);
        write_reg(REG_FRAME_HEIGHT, 13'd1);
        send_pixel('0);
        send_pixel('1);
        settle_block();
        write_reg(REG_FRAME_WIDTH, 13'd2);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        send_pixel('1);
        send_pixel('0);
        send_pixel('0);
        send_pixel('1);
        send_pixel('1);
        send_pixel('1);
        settle_block();
    endtask

    task automatic test_midframe_write();
        write_reg(REG_FRAME_WIDTH, 13'd4);
        write_reg(REG_FRAME_HEIGHT, 13'd4);
        repeat (6) send_pixel(pick_pixel());
        settle_block();
        // column 2 is now past the end, and row 1 becomes the last row
        write_reg(REG_FRAME_WIDTH, 13'd2);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        send_pixel(pick_pixel());
        settle_block();
        repeat (4) send_pixel(pick_pixel());
        settle_block();
    endtask

    task automatic test_random_frames();
        int unsigned      sent;
        int unsigned      frames;
        int unsigned      chunk;
        int unsigned      cur_w;
        logic [DIM_W-1:0] w_val;
        logic [DIM_W-1:0] h_val;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            settle_block();
            case ($urandom_range(0, 9))
                0: w_val = '0;
                9: w_val = DIM_W'($urandom_range(17, 40));
                default: w_val = DIM_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 9))
                0: h_val = '0;
                9: h_val = DIM_W'($urandom_range(7, 10));
                default: h_val = DIM_W'($urandom_range(1, 6));
            endcase
            // past row 0 the width may only shrink, or a column reads unwritten
            cur_w = bounded_dim(cfg_width, MAX_W);
            if (row_pos != 0 && bounded_dim(w_val, MAX_W) > cur_w)
                w_val = DIM_W'($urandom_range(1, cur_w));
            if ($urandom_range(0, 9) < 7)
                write_reg(REG_FRAME_WIDTH, w_val);
            if ($urandom_range(0, 9) < 7)
                write_reg(REG_FRAME_HEIGHT, h_val);
            if ($urandom_range(0, 4) == 0) begin
                chunk = $urandom_range(1, 40);
                repeat (chunk) send_pixel(pick_pixel());
                sent += chunk;
            end else begin
                frames = $urandom_range(1, 3);
                repeat (frames) begin
                    do begin
                        send_pixel(pick_pixel());
                        sent++;
                    end while (row_pos != 0 || col_pos != 0);
                end
            end
        end
        settle_block();
    endtask

    task automatic test_oversized_dims();
        // finish the running frame so the wide row starts on row 0
        while (row_pos != 0 || col_pos != 0)
            send_pixel(pick_pixel());
        settle_block();
        // 8191 clamps to the maximum: a short run stays inside row 0
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, '1);
        repeat (20) send_pixel(pick_pixel());
        settle_block();
        // narrowing under the position ends row 0, then a last row of four
        write_reg(REG_FRAME_WIDTH, 13'd4);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        repeat (5) send_pixel(pick_pixel());
        settle_block();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_defaults_and_spare_regs();
        test_extreme_pixels();
        test_midframe_write();
        test_random_frames();
        test_oversized_dims();
        settle_block();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
